// ===== src/dpfc_pkg.sv =====
// Shared types and constants for the display pixel format and cursor blend core.
package dpfc_pkg;

	localparam int COORD_LIMIT = 2048;
	localparam int CURSOR_MAX  = 256;

	localparam int COORD_W   = 11;
	localparam int CUR_POS_W = 16;
	localparam int CUR_EXT_W = 11;
	localparam int FMT_W     = 5;
	localparam int CMP_W     = 12;
	localparam int EDGE_W    = CUR_POS_W + 1;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [FMT_W-1:0] FMT_RGB565 = 5'd6;
	localparam logic [FMT_W-1:0] FMT_RGB32  = 5'd8;

	localparam logic [7:0] ALPHA_FULL = 8'd255;

	typedef enum logic [2:0] {
		REG_FORMAT  = 3'd0,
		REG_CUR_EN  = 3'd1,
		REG_CUR_X   = 3'd2,
		REG_CUR_Y   = 3'd3,
		REG_CUR_WM1 = 3'd4,
		REG_CUR_HM1 = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MIX_KEEP    = 2'd0,
		MIX_REPLACE = 2'd1,
		MIX_BLEND   = 2'd2
	} mix_mode_t;

	typedef struct packed {
		logic [FMT_W-1:0]     pixel_format;
		logic                 cursor_enable;
		logic [CUR_POS_W-1:0] cursor_x;
		logic [CUR_POS_W-1:0] cursor_y;
		logic [CUR_EXT_W-1:0] cursor_w_minus1;
		logic [CUR_EXT_W-1:0] cursor_h_minus1;
	} cfg_t;

	typedef struct packed {
		logic [7:0] base_r;
		logic [7:0] base_g;
		logic [7:0] base_b;
		logic [7:0] tex_a;
		logic [7:0] tex_r;
		logic [7:0] tex_g;
		logic [7:0] tex_b;
		logic       hit;
		mix_mode_t  mode;
	} mid_item_t;

endpackage

// ===== src/dpfc_regs.sv =====
// APB configuration register file.
module dpfc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dpfc_pkg::PADDR_W-1:0] paddr,
	input  logic [dpfc_pkg::PDATA_W-1:0] pwdata,
	output logic [dpfc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output dpfc_pkg::cfg_t               cfg
);
	import dpfc_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_FORMAT:  cfg_q.pixel_format    <= pwdata[FMT_W-1:0];
				REG_CUR_EN:  cfg_q.cursor_enable   <= pwdata[0];
				REG_CUR_X:   cfg_q.cursor_x        <= pwdata[CUR_POS_W-1:0];
				REG_CUR_Y:   cfg_q.cursor_y        <= pwdata[CUR_POS_W-1:0];
				REG_CUR_WM1: cfg_q.cursor_w_minus1 <= pwdata[CUR_EXT_W-1:0];
				REG_CUR_HM1: cfg_q.cursor_h_minus1 <= pwdata[CUR_EXT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_FORMAT:  prdata = PDATA_W'(cfg_q.pixel_format);
			REG_CUR_EN:  prdata = PDATA_W'(cfg_q.cursor_enable);
			REG_CUR_X:   prdata = PDATA_W'(cfg_q.cursor_x);
			REG_CUR_Y:   prdata = PDATA_W'(cfg_q.cursor_y);
			REG_CUR_WM1: prdata = PDATA_W'(cfg_q.cursor_w_minus1);
			REG_CUR_HM1: prdata = PDATA_W'(cfg_q.cursor_h_minus1);
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== src/dpfc_front.sv =====
// Front end: pixel format conversion, cursor hit test and blend classification.
module dpfc_front (
	input  dpfc_pkg::cfg_t               cfg,
	input  logic [31:0]                  raw_pixel,
	input  logic [dpfc_pkg::COORD_W-1:0] pixel_x,
	input  logic [dpfc_pkg::COORD_W-1:0] pixel_y,
	input  logic [31:0]                  cursor_texel,
	output dpfc_pkg::mid_item_t          item
);
	import dpfc_pkg::*;

	logic [7:0]        r, g, b;
	logic              size_ok, on_screen, x_in, y_in, hit;
	logic [EDGE_W-1:0] x_last, y_last;

	always_comb begin
		case (cfg.pixel_format) inside
			FMT_RGB565: begin
				r = {raw_pixel[15:11], 3'b000};
				g = {raw_pixel[10:5], 2'b00};
				b = {raw_pixel[4:0], 3'b000};
			end
			[FMT_RGB32:5'd31]: begin
				r = raw_pixel[7:0];
				g = raw_pixel[15:8];
				b = raw_pixel[23:16];
			end
			default: begin
				r = raw_pixel[7:0];
				g = raw_pixel[7:0];
				b = raw_pixel[7:0];
			end
		endcase
	end

	assign size_ok = (CMP_W'(cfg.cursor_w_minus1) < CMP_W'(CURSOR_MAX))
	              && (CMP_W'(cfg.cursor_h_minus1) < CMP_W'(CURSOR_MAX));
	assign on_screen = (CMP_W'(pixel_x) < CMP_W'(COORD_LIMIT))
	                && (CMP_W'(pixel_y) < CMP_W'(COORD_LIMIT));

	assign x_last = EDGE_W'(cfg.cursor_x) + EDGE_W'(cfg.cursor_w_minus1);
	assign y_last = EDGE_W'(cfg.cursor_y) + EDGE_W'(cfg.cursor_h_minus1);
	assign x_in   = (CUR_POS_W'(pixel_x) >= cfg.cursor_x) && (EDGE_W'(pixel_x) <= x_last);
	assign y_in   = (CUR_POS_W'(pixel_y) >= cfg.cursor_y) && (EDGE_W'(pixel_y) <= y_last);
	assign hit    = cfg.cursor_enable && size_ok && on_screen && x_in && y_in;

	always_comb begin
		item.base_r = r;
		item.base_g = g;
		item.base_b = b;
		item.tex_a  = cursor_texel[31:24];
		item.tex_r  = cursor_texel[23:16];
		item.tex_g  = cursor_texel[15:8];
		item.tex_b  = cursor_texel[7:0];
		item.hit    = hit;
		if (!hit || cursor_texel[31:24] == 8'd0) begin
			item.mode = MIX_KEEP;
		end else if (cursor_texel[31:24] == ALPHA_FULL) begin
			item.mode = MIX_REPLACE;
		end else begin
			item.mode = MIX_BLEND;
		end
	end

endmodule

// ===== src/dpfc_queue.sv =====
// Short queue between the front end and the blend back end.
module dpfc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dpfc_pkg::mid_item_t item_in,
	output logic                full,
	input  logic                pop,
	output dpfc_pkg::mid_item_t item_out,
	output logic                empty
);
	import dpfc_pkg::*;

	mid_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign item_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/dpfc_back.sv =====
// Back end: two-stage alpha blend pipeline feeding the result queue.
module dpfc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dpfc_pkg::mid_item_t mid_item,
	input  logic                mid_empty,
	output logic                mid_pop,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue,
	output logic                cursor_hit,
	output logic                empty,
	input  logic                pop
);
	import dpfc_pkg::*;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       hit;
	} out_item_t;

	function automatic logic [15:0] mix(input logic [7:0] c, input logic [7:0] base,
	                                    input logic [7:0] a);
		logic [15:0] p0, p1;
		p0  = 16'(c) * 16'(a);
		p1  = 16'(base) * 16'(ALPHA_FULL - a);
		mix = p0 + p1;
	endfunction

	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t      = 17'(x) + 17'(x[15:8]) + 17'd1;
		div255 = t[15:8];
	endfunction

	logic        adv, out_full, out_push, out_pop;
	logic        v_s1, v_s2;
	logic [15:0] sum_r_s1, sum_g_s1, sum_b_s1;
	logic [7:0]  pass_r_s1, pass_g_s1, pass_b_s1;
	logic        hit_s1;
	mix_mode_t   mode_s1;
	out_item_t   res_s2;

	out_item_t         oq_q [QDEPTH];
	logic [QPTR_W-1:0] owr_q, ord_q;
	logic [QCNT_W-1:0] ocnt_q;

	assign out_full = (ocnt_q == QCNT_W'(QDEPTH));
	assign empty    = (ocnt_q == '0);
	assign adv      = !v_s2 || !out_full;
	assign out_push = v_s2 && !out_full;
	assign out_pop  = pop && !empty;
	assign mid_pop  = adv && !mid_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !mid_empty;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_r_s1 <= mix(mid_item.tex_r, mid_item.base_r, mid_item.tex_a);
			sum_g_s1 <= mix(mid_item.tex_g, mid_item.base_g, mid_item.tex_a);
			sum_b_s1 <= mix(mid_item.tex_b, mid_item.base_b, mid_item.tex_a);
			hit_s1   <= mid_item.hit;
			mode_s1  <= mid_item.mode;
			if (mid_item.mode == MIX_REPLACE) begin
				pass_r_s1 <= mid_item.tex_r;
				pass_g_s1 <= mid_item.tex_g;
				pass_b_s1 <= mid_item.tex_b;
			end else begin
				pass_r_s1 <= mid_item.base_r;
				pass_g_s1 <= mid_item.base_g;
				pass_b_s1 <= mid_item.base_b;
			end
			res_s2.hit <= hit_s1;
			if (mode_s1 == MIX_BLEND) begin
				res_s2.r <= div255(sum_r_s1);
				res_s2.g <= div255(sum_g_s1);
				res_s2.b <= div255(sum_b_s1);
			end else begin
				res_s2.r <= pass_r_s1;
				res_s2.g <= pass_g_s1;
				res_s2.b <= pass_b_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			oq_q[owr_q] <= res_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (out_push) begin
				owr_q <= owr_q + 1'b1;
			end
			if (out_pop) begin
				ord_q <= ord_q + 1'b1;
			end
			if (out_push && !out_pop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (out_pop && !out_push) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	assign red        = oq_q[ord_q].r;
	assign green      = oq_q[ord_q].g;
	assign blue       = oq_q[ord_q].b;
	assign cursor_hit = oq_q[ord_q].hit;

endmodule

// ===== src/display_pixel_format_and_cursor_blend_core.sv =====
// Top level of the display pixel format conversion and cursor blend core.
//
//   channel   handshake                     payload
//   pixel in  push / full                   raw_pixel, pixel_x, pixel_y, cursor_texel
//   result    empty / pop                   red, green, blue, cursor_hit
//   config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One pixel per clock sustained while the result side keeps popping; a pixel's result
// reaches the head of the result queue through the input queue write, product stage,
// divide stage and result queue write.
// Reset clears the registers and empties both queues; no clearing pass is needed.
// A stalled result side fills the four-entry result queue, then the blend stages,
// then the four-entry input queue, after which full rises.
module display_pixel_format_and_cursor_blend_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dpfc_pkg::PADDR_W-1:0] paddr,
	input  logic [dpfc_pkg::PDATA_W-1:0] pwdata,
	output logic [dpfc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         push,
	output logic                         full,
	input  logic [31:0]                  raw_pixel,
	input  logic [dpfc_pkg::COORD_W-1:0] pixel_x,
	input  logic [dpfc_pkg::COORD_W-1:0] pixel_y,
	input  logic [31:0]                  cursor_texel,
	output logic                         empty,
	input  logic                         pop,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	output logic                         cursor_hit
);
	import dpfc_pkg::*;

	cfg_t      cfg;
	mid_item_t front_item, mid_item;
	logic      mid_empty, mid_pop;

	dpfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dpfc_front u_front (
		.cfg          (cfg),
		.raw_pixel    (raw_pixel),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.cursor_texel (cursor_texel),
		.item         (front_item)
	);

	dpfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (front_item),
		.full     (full),
		.pop      (mid_pop),
		.item_out (mid_item),
		.empty    (mid_empty)
	);

	dpfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_item   (mid_item),
		.mid_empty  (mid_empty),
		.mid_pop    (mid_pop),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.cursor_hit (cursor_hit),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// ===== tb/display_pixel_format_and_cursor_blend_core_tb.sv =====
// Self-checking testbench for the display pixel format and cursor blend core.
`timescale 1ns / 1ps

module display_pixel_format_and_cursor_blend_core_tb;
	import dpfc_pkg::*;

	localparam int CYCLE_LIMIT  = 400_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_LEN     = 64;
	localparam int PHASES       = 24;
	localparam int PHASE_PIXELS = 75;
	localparam int PRESSURE_PHASE = 4;
	localparam int REG_COUNT    = 6;
	localparam int MAX_REPORTS  = 10;

	localparam logic [FMT_W-1:0] FMT_GREY = 5'd0;
	localparam logic [FMT_W-1:0] FMT_GAP  = FMT_RGB565 + 5'd1;
	localparam logic [FMT_W-1:0] FMT_TOP  = 5'd31;

	typedef struct packed {
		logic [31:0]        raw;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [31:0]        texel;
	} pixel_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       hit;
	} pixel_rgb_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 push = 1'b0;
	logic                 full;
	logic [31:0]          raw_pixel = '0;
	logic [COORD_W-1:0]   pixel_x = '0;
	logic [COORD_W-1:0]   pixel_y = '0;
	logic [31:0]          cursor_texel = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic                 cursor_hit;

	cfg_t        cfg_now = '0;
	pixel_req_t  pixel_queue[$];
	pixel_rgb_t  expected_px[$];
	pixel_req_t  cur_pixel;
	pixel_rgb_t  head_px;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_req = 1'b0;
	int          hold_cnt = 0;
	logic        rx_hold;
	int          fail_count = 0;
	int          pixels_sent = 0;
	int          results_seen = 0;
	int          hits_seen = 0;
	int          full_stalls = 0;
	int          configs_run = 0;
	int          cycle_count = 0;

	display_pixel_format_and_cursor_blend_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.raw_pixel(raw_pixel),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.cursor_texel(cursor_texel),
		.empty(empty),
		.pop(pop),
		.red(red),
		.green(green),
		.blue(blue),
		.cursor_hit(cursor_hit)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] mix_channel(input logic [7:0] c, input logic [7:0] base,
			input logic [7:0] a);
		int unsigned t;
		t = (int'(c) * int'(a) + int'(base) * (int'(ALPHA_FULL) - int'(a))) / int'(ALPHA_FULL);
		return 8'(t);
	endfunction

	function automatic pixel_rgb_t blend_pixel(input cfg_t c, input pixel_req_t p);
		pixel_rgb_t  o;
		logic [7:0]  alpha;
		int unsigned cw, ch, cx, cy;
		cw = int'(c.cursor_w_minus1) + 1;
		ch = int'(c.cursor_h_minus1) + 1;
		cx = c.cursor_x;
		cy = c.cursor_y;
		if (c.pixel_format == FMT_RGB565) begin
			o.red   = {p.raw[15:11], 3'b000};
			o.green = {p.raw[10:5], 2'b00};
			o.blue  = {p.raw[4:0], 3'b000};
		end else if (c.pixel_format >= FMT_RGB32) begin
			o.red   = p.raw[7:0];
			o.green = p.raw[15:8];
			o.blue  = p.raw[23:16];
		end else begin
			o.red   = p.raw[7:0];
			o.green = p.raw[7:0];
			o.blue  = p.raw[7:0];
		end
		o.hit = (c.cursor_enable && cw <= CURSOR_MAX && ch <= CURSOR_MAX &&
			p.x < COORD_LIMIT && p.y < COORD_LIMIT &&
			p.x >= cx && p.x < cx + cw && p.y >= cy && p.y < cy + ch) ? 1'b1 : 1'b0;
		alpha = p.texel[31:24];
		if (o.hit && alpha == ALPHA_FULL) begin
			o.red   = p.texel[23:16];
			o.green = p.texel[15:8];
			o.blue  = p.texel[7:0];
		end else if (o.hit && alpha != 8'd0) begin
			o.red   = mix_channel(p.texel[23:16], o.red, alpha);
			o.green = mix_channel(p.texel[15:8], o.green, alpha);
			o.blue  = mix_channel(p.texel[7:0], o.blue, alpha);
		end
		return o;
	endfunction

	function automatic logic [31:0] reg_image(input int idx);
		case (idx)
			REG_FORMAT:  return 32'(cfg_now.pixel_format);
			REG_CUR_EN:  return 32'(cfg_now.cursor_enable);
			REG_CUR_X:   return 32'(cfg_now.cursor_x);
			REG_CUR_Y:   return 32'(cfg_now.cursor_y);
			REG_CUR_WM1: return 32'(cfg_now.cursor_w_minus1);
			REG_CUR_HM1: return 32'(cfg_now.cursor_h_minus1);
			default:     return 32'd0;
		endcase
	endfunction

	// random junk above the register's width; the block must drop it
	function automatic logic [31:0] junk_above(input logic [31:0] value, input int width);
		logic [31:0] j;
		j = $urandom();
		return (j << width) | value;
	endfunction

	function automatic logic [CUR_EXT_W-1:0] pick_extent();
		case ($urandom_range(0, 9))
			7:       return CUR_EXT_W'(CURSOR_MAX - 1);
			8:       return CUR_EXT_W'(CURSOR_MAX);
			9:       return CUR_EXT_W'($urandom_range(0, 2047));
			default: return CUR_EXT_W'($urandom_range(0, 63));
		endcase
	endfunction

	function automatic logic [CUR_POS_W-1:0] pick_position();
		case ($urandom_range(0, 7))
			6:       return CUR_POS_W'($urandom_range(COORD_LIMIT - 150, COORD_LIMIT - 1));
			7:       return CUR_POS_W'($urandom_range(0, 65535));
			default: return CUR_POS_W'($urandom_range(0, COORD_LIMIT - 1));
		endcase
	endfunction

	task automatic note_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			note_fail($sformatf("%s expected %0h, got %0h", what, want, got));
	endtask

	task automatic apb_write(input int idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input int idx, output logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input int idx, input logic [31:0] value);
		apb_write(idx, value);
		case (idx)
			REG_FORMAT:  cfg_now.pixel_format = value[FMT_W-1:0];
			REG_CUR_EN:  cfg_now.cursor_enable = value[0];
			REG_CUR_X:   cfg_now.cursor_x = value[CUR_POS_W-1:0];
			REG_CUR_Y:   cfg_now.cursor_y = value[CUR_POS_W-1:0];
			REG_CUR_WM1: cfg_now.cursor_w_minus1 = value[CUR_EXT_W-1:0];
			REG_CUR_HM1: cfg_now.cursor_h_minus1 = value[CUR_EXT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_regs();
		logic [31:0] got;
		for (int i = 0; i < REG_COUNT; i++) begin
			apb_read(i, got);
			check_field($sformatf("register %0d readback", i), reg_image(i), got);
		end
	endtask

	task automatic drain_pipe();
		do @(negedge clk);
		while (pixel_queue.size() != 0 || expected_px.size() != 0 || push);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(input logic [FMT_W-1:0] fmt, input logic en,
			input logic [CUR_POS_W-1:0] cx, input logic [CUR_POS_W-1:0] cy,
			input logic [CUR_EXT_W-1:0] wm1, input logic [CUR_EXT_W-1:0] hm1);
		drain_pipe();
		write_reg(REG_FORMAT, junk_above(32'(fmt), FMT_W));
		write_reg(REG_CUR_EN, junk_above(32'(en), 1));
		write_reg(REG_CUR_X, junk_above(32'(cx), CUR_POS_W));
		write_reg(REG_CUR_Y, junk_above(32'(cy), CUR_POS_W));
		write_reg(REG_CUR_WM1, junk_above(32'(wm1), CUR_EXT_W));
		write_reg(REG_CUR_HM1, junk_above(32'(hm1), CUR_EXT_W));
		check_regs();
		configs_run++;
	endtask

	task automatic queue_pixel(input logic [31:0] raw, input int x, input int y,
			input logic [31:0] texel);
		pixel_req_t p;
		p.raw = raw;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.texel = texel;
		pixel_queue.push_back(p);
	endtask

	// mostly around the cursor box so hits and both edges get exercised
	task automatic queue_random_pixel();
		int          x, y;
		int unsigned cw, ch;
		logic [7:0]  alpha;
		cw = int'(cfg_now.cursor_w_minus1) + 1;
		ch = int'(cfg_now.cursor_h_minus1) + 1;
		x = $urandom_range(0, COORD_LIMIT - 1);
		y = $urandom_range(0, COORD_LIMIT - 1);
		if ($urandom_range(0, 9) < 7) begin
			x = int'(cfg_now.cursor_x) - 2 + int'($urandom_range(0, cw + 3));
			y = int'(cfg_now.cursor_y) - 2 + int'($urandom_range(0, ch + 3));
			if (x < 0 || x >= COORD_LIMIT)
				x = $urandom_range(0, COORD_LIMIT - 1);
			if (y < 0 || y >= COORD_LIMIT)
				y = $urandom_range(0, COORD_LIMIT - 1);
		end
		case ($urandom_range(0, 3))
			0:       alpha = 8'd0;
			1:       alpha = ALPHA_FULL;
			default: alpha = 8'($urandom());
		endcase
		queue_pixel($urandom(), x, y, {alpha, 24'($urandom())});
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_px.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!hold_req)
			hold_cnt <= 0;
		else if (hold_cnt < HOLD_LEN)
			hold_cnt <= hold_cnt + 1;
	end

	assign rx_hold = hold_req && hold_cnt < HOLD_LEN;

	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				expected_px.push_back(blend_pixel(cfg_now, cur_pixel));
				pixels_sent++;
			end
			if (push && full)
				full_stalls++;
			if (!push || !full) begin
				if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_pixel = pixel_queue.pop_front();
					push <= 1'b1;
					raw_pixel <= cur_pixel.raw;
					pixel_x <= cur_pixel.x;
					pixel_y <= cur_pixel.y;
					cursor_texel <= cur_pixel.texel;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_px.size() == 0) begin
					note_fail($sformatf("result %0d arrived with nothing outstanding",
						results_seen));
				end else begin
					head_px = expected_px.pop_front();
					check_field($sformatf("red of result %0d", results_seen),
						32'(head_px.red), 32'(red));
					check_field($sformatf("green of result %0d", results_seen),
						32'(head_px.green), 32'(green));
					check_field($sformatf("blue of result %0d", results_seen),
						32'(head_px.blue), 32'(blue));
					check_field($sformatf("cursor_hit of result %0d", results_seen),
						32'(head_px.hit), 32'(cursor_hit));
					hits_seen += head_px.hit;
				end
				results_seen++;
			end
			pop <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		logic [FMT_W-1:0] fmt;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, then writes past the last register must change nothing
		check_regs();
		write_reg(REG_COUNT, $urandom());
		write_reg(REG_COUNT + 1, $urandom());
		check_regs();

		queue_pixel(32'hffff_ffff, 0, 0, 32'hff00_0000);
		queue_pixel(32'h0000_0000, COORD_LIMIT - 1, COORD_LIMIT - 1, 32'hffff_ffff);

		// largest legal cursor, edges of the box from inside and outside
		set_config(FMT_RGB565, 1'b1, 16'd100, 16'd50, CUR_EXT_W'(CURSOR_MAX - 1),
			CUR_EXT_W'(CURSOR_MAX - 1));
		queue_pixel(32'h0000_ffff, 100, 50, 32'h00ab_cdef);
		queue_pixel(32'h0000_0000, 355, 305, 32'hff12_3456);
		queue_pixel(32'h0000_f800, 200, 100, 32'h80ff_ffff);
		queue_pixel(32'hffff_07e0, 200, 100, 32'h01ff_00ff);
		queue_pixel(32'h0000_001f, 356, 100, 32'hffff_ffff);
		queue_pixel(32'h0000_001f, 99, 100, 32'hffff_ffff);
		queue_pixel(32'h0000_001f, 200, 306, 32'hffff_ffff);
		queue_pixel(32'h0000_001f, 200, 49, 32'hffff_ffff);

		// cursor hanging off the bottom right corner of the screen
		set_config(FMT_RGB32, 1'b1, 16'd1900, 16'd1950, CUR_EXT_W'(CURSOR_MAX - 1),
			CUR_EXT_W'(CURSOR_MAX - 1));
		queue_pixel(32'hffff_ffff, COORD_LIMIT - 1, COORD_LIMIT - 1, 32'hfe00_0000);
		queue_pixel(32'h00c0_8040, 1900, 1950, 32'hff10_2030);
		queue_pixel(32'h00c0_8040, 1899, 2000, 32'hff10_2030);

		// oversized cursor in either direction disables the overlay
		set_config(FMT_GAP, 1'b1, 16'd0, 16'd0, CUR_EXT_W'(CURSOR_MAX), 11'd0);
		queue_pixel(32'h1234_5678, 0, 0, 32'hffff_ffff);
		set_config(FMT_TOP, 1'b1, 16'd0, 16'd0, 11'd0, CUR_EXT_W'(CURSOR_MAX));
		queue_pixel(32'h1234_5678, 0, 0, 32'hffff_ffff);
		set_config(FMT_GREY, 1'b1, 16'hffff, 16'hffff, 11'h7ff, 11'h7ff);
		queue_pixel(32'h0000_0080, COORD_LIMIT - 1, COORD_LIMIT - 1, 32'hffff_ffff);
		set_config(FMT_GREY, 1'b0, 16'd0, 16'd0, 11'd7, 11'd7);
		queue_pixel(32'h0000_0080, 3, 3, 32'hffff_ffff);

		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 5))
				0:       fmt = FMT_RGB565;
				1:       fmt = FMT_RGB32;
				2:       fmt = FMT_TOP;
				3:       fmt = FMT_GREY;
				4:       fmt = FMT_GAP;
				default: fmt = FMT_W'($urandom_range(0, 31));
			endcase
			set_config(fmt, $urandom_range(0, 5) != 0, pick_position(), pick_position(),
				pick_extent(), pick_extent());
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			hold_req = (p == PRESSURE_PHASE);
			repeat (PHASE_PIXELS) queue_random_pixel();
			drain_pipe();
			hold_req = 1'b0;
		end

		drain_pipe();
		$display("covered %0d pixels over %0d register settings: %0d results checked, %0d cursor hits",
			pixels_sent, configs_run, results_seen, hits_seen);
		$display("input held off by full for %0d cycles; %0d mismatches", full_stalls, fail_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
